>>> sv/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared widths, register indexes, mode codes and the job record that moves
// from the accumulating front end to the dividing back end.
// ----------------------------------------------------------------------------
package bmp_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 8;
	localparam int MEAN_W    = 33;
	localparam int MODE_W    = 2;
	localparam int LEN_W     = 21;
	localparam int INDEX_W   = 2;
	localparam int SUM_A_W   = 37;
	localparam int SUM_B_W   = 35;

	// Fixed-point and block limits
	localparam int FRAC_BITS  = 16;
	localparam int MAX_BLOCK  = 1048576;
	localparam int LEN_RESET  = 1024;

	// Divider sizing: quotient of (sum << FRAC_BITS) / len fits MEAN_W bits
	localparam int DIVIDEND_W = SUM_A_W + FRAC_BITS;
	localparam int REM_W      = LEN_W;
	localparam int STEP_W     = $clog2(MEAN_W);

	// Job queue between front and back
	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

	// Mode codes (the spare code behaves as single channel)
	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DUAL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd2;

	// Register indexes
	localparam logic [INDEX_W-1:0] REG_MODE         = 2'd0;
	localparam logic [INDEX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

	// One finished block waiting for division
	typedef struct packed {
		logic [SUM_A_W-1:0] sum_a;
		logic [SUM_B_W-1:0] sum_b;
		logic [LEN_W-1:0]   len;
		logic               dual;
	} job_t;

endpackage

>>> sv/bmp_front.sv
// ----------------------------------------------------------------------------
// bmp_front
// Holds the configuration, squares and accumulates samples, and hands each
// finished block to the job queue.
// ----------------------------------------------------------------------------
module bmp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [bmp_pkg::SAMPLE_W-1:0] sample,
	input  logic                         wr_en,
	input  logic [bmp_pkg::INDEX_W-1:0]  wr_index,
	input  logic [bmp_pkg::LEN_W-1:0]    wr_data,
	input  logic                         jobq_full,
	output logic                         job_push,
	output bmp_pkg::job_t                job
);
	import bmp_pkg::*;

	logic [MODE_W-1:0]          mode_q;
	logic [LEN_W-1:0]           blen_q;
	logic [SUM_A_W-1:0]         sum_a_q;
	logic [SUM_B_W-1:0]         sum_b_q;
	logic signed [SAMPLE_W-1:0] held_q;
	logic [LEN_W-1:0]           count_q;
	logic                       odd_q;

	logic [LEN_W-1:0]           len_eff;
	logic                       pair_mode;
	logic                       term_done;
	logic [LEN_W-1:0]           count_next;
	logic                       block_end;
	logic                       accept;
	logic                       cfg_hit;
	logic signed [SAMPLE_W-1:0] s;
	logic signed [SAMPLE_W:0]   x;
	logic signed [2*SAMPLE_W+1:0] xx;
	logic signed [2*SAMPLE_W-1:0] ss;
	logic [SUM_A_W-1:0]         sum_a_next;
	logic [SUM_B_W-1:0]         sum_b_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
			blen_q <= LEN_W'(LEN_RESET);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:         mode_q <= wr_data[MODE_W-1:0];
				REG_BLOCK_LENGTH: blen_q <= wr_data;
				default:          ;
			endcase
		end
	end

	assign cfg_hit = wr_en && (wr_index == REG_MODE || wr_index == REG_BLOCK_LENGTH);

	// Effective block length: zero reads as one, large values clamp
	always_comb begin
		if (blen_q == '0)
			len_eff = LEN_W'(1);
		else if (blen_q > LEN_W'(MAX_BLOCK))
			len_eff = LEN_W'(MAX_BLOCK);
		else
			len_eff = blen_q;
	end

	assign pair_mode  = (mode_q == MODE_DUAL) || (mode_q == MODE_PAIR);
	assign term_done  = !pair_mode || odd_q;
	assign count_next = count_q + LEN_W'(1);
	assign block_end  = term_done && (count_next >= len_eff);

	// Only a block-closing beat needs a free queue slot
	assign full   = jobq_full && block_end;
	assign accept = push && !full;

	// Squares: one 9-bit operand for the first sum, the raw sample for the second
	assign s = sample;
	always_comb begin
		if (mode_q == MODE_PAIR)
			x = {held_q[SAMPLE_W-1], held_q} + {s[SAMPLE_W-1], s};
		else if (mode_q == MODE_DUAL)
			x = {held_q[SAMPLE_W-1], held_q};
		else
			x = {s[SAMPLE_W-1], s};
	end
	assign xx = x * x;
	assign ss = s * s;

	assign sum_a_next = sum_a_q + SUM_A_W'(xx[2*SAMPLE_W:0]);
	assign sum_b_next = (mode_q == MODE_DUAL) ?
		sum_b_q + SUM_B_W'(ss[2*SAMPLE_W-2:0]) : sum_b_q;

	// Accumulation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			held_q  <= '0;
			count_q <= '0;
			odd_q   <= 1'b0;
		end else if (cfg_hit) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			held_q  <= '0;
			count_q <= '0;
			odd_q   <= 1'b0;
		end else if (accept) begin
			if (pair_mode && !odd_q) begin
				held_q <= s;
				odd_q  <= 1'b1;
			end else begin
				odd_q  <= 1'b0;
				held_q <= '0;
				if (block_end) begin
					sum_a_q <= '0;
					sum_b_q <= '0;
					count_q <= '0;
				end else begin
					sum_a_q <= sum_a_next;
					sum_b_q <= sum_b_next;
					count_q <= count_next;
				end
			end
		end
	end

	// Job handed to the back end
	assign job_push  = accept && block_end;
	assign job.sum_a = sum_a_next;
	assign job.sum_b = sum_b_next;
	assign job.len   = len_eff;
	assign job.dual  = (mode_q == MODE_DUAL);

endmodule

>>> sv/bmp_queue.sv
// ----------------------------------------------------------------------------
// bmp_queue
// Short job queue between the accumulating front end and the divider.
// ----------------------------------------------------------------------------
module bmp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  bmp_pkg::job_t wr_job,
	output logic          q_full,
	input  logic          rd,
	output bmp_pkg::job_t rd_job,
	output logic          q_empty
);
	import bmp_pkg::*;

	job_t                  slot_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wptr_q;
	logic [JOBQ_PTR_W-1:0] rptr_q;
	logic [JOBQ_PTR_W:0]   cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = (cnt_q == (JOBQ_PTR_W+1)'(JOBQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_job  = slot_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wptr_q] <= wr_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + JOBQ_PTR_W'(1);
			if (do_rd)
				rptr_q <= rptr_q + JOBQ_PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + (JOBQ_PTR_W+1)'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - (JOBQ_PTR_W+1)'(1);
		end
	end

endmodule

>>> sv/bmp_back.sv
// ----------------------------------------------------------------------------
// bmp_back
// Restoring divider, one quotient bit per cycle, producing the block mean
// (sum << FRAC_BITS) / len, and the output register facing the result port.
// ----------------------------------------------------------------------------
module bmp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       jobq_empty,
	input  bmp_pkg::job_t              jobq_data,
	output logic                       jobq_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [bmp_pkg::MEAN_W-1:0] mean_power,
	output logic                       channel,
	output logic                       last
);
	import bmp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

	back_state_t         state_q;
	job_t                job_q;
	logic                chan_q;
	logic [REM_W-1:0]    rem_q;
	logic [MEAN_W-1:0]   quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic [MEAN_W-1:0]   out_mean_q;
	logic                out_chan_q;
	logic                out_last_q;

	logic [DIVIDEND_W-1:0] dividend;
	logic [SUM_A_W-1:0]    load_sum;
	logic [REM_W:0]        trial;
	logic [REM_W:0]        diff;
	logic                  ge;
	logic                  slot_free;
	logic                  out_wr;
	logic                  second_pending;

	// Divider step: shift one dividend bit in, subtract if it fits
	assign trial = {rem_q, quo_q[MEAN_W-1]};
	assign diff  = trial - {1'b0, job_q.len};
	assign ge    = (trial >= {1'b0, job_q.len});

	// Channel 1 of a dual job reuses the unit after channel 0
	assign load_sum = (state_q == ST_IDLE) ? jobq_data.sum_a : SUM_A_W'(job_q.sum_b);
	assign dividend = {load_sum, {FRAC_BITS{1'b0}}};

	assign jobq_pop       = (state_q == ST_IDLE) && !jobq_empty;
	assign slot_free      = !out_valid_q || pop;
	assign out_wr         = (state_q == ST_DONE) && slot_free;
	assign second_pending = job_q.dual && !chan_q;

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!jobq_empty) begin
						state_q <= ST_RUN;
						chan_q  <= 1'b0;
						step_q  <= STEP_W'(MEAN_W - 1);
					end
				end
				ST_RUN: begin
					if (step_q == '0)
						state_q <= ST_DONE;
					else
						step_q <= step_q - STEP_W'(1);
				end
				ST_DONE: begin
					if (slot_free) begin
						if (second_pending) begin
							state_q <= ST_RUN;
							chan_q  <= 1'b1;
							step_q  <= STEP_W'(MEAN_W - 1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (jobq_pop)
			job_q <= jobq_data;
		if (jobq_pop || (out_wr && second_pending)) begin
			rem_q <= REM_W'(dividend[DIVIDEND_W-1:MEAN_W]);
			quo_q <= dividend[MEAN_W-1:0];
		end else if (state_q == ST_RUN) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			quo_q <= {quo_q[MEAN_W-2:0], ge};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_wr)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_mean_q <= quo_q;
			out_chan_q <= chan_q;
			out_last_q <= !second_pending;
		end
	end

	assign empty      = !out_valid_q;
	assign mean_power = out_mean_q;
	assign channel    = out_chan_q;
	assign last       = out_last_q;

endmodule

>>> sv/block_mean_power_top.sv
// ----------------------------------------------------------------------------
// block_mean_power_top
// Block mean-square power integrator over signed 8-bit samples.
//
//   channel   direction  handshake          beat contents
//   sample    in         push / full        sample
//   result    out        empty / pop        mean_power, channel, last
//   config    in         wr_en              wr_index, wr_data
//
// One sample beat is taken per cycle; full rises only when a beat would close
// a block while both job queue slots are occupied.
// A one-result job holds the back end through a load, 33 restoring divider
// steps of one quotient bit and an output write; a two-channel job reloads
// for channel 1 during the channel 0 output write and runs the steps again,
// so with short blocks the sustained rate is set by the divider.
// Reset clears mode to 0, block_length to 1024 and all accumulators; no
// clearing pass. A stalled result holds the divider, which backs up the queue.
// ----------------------------------------------------------------------------
module block_mean_power_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [bmp_pkg::SAMPLE_W-1:0] sample,
	output logic                         empty,
	input  logic                         pop,
	output logic [bmp_pkg::MEAN_W-1:0]   mean_power,
	output logic                         channel,
	output logic                         last,
	input  logic                         wr_en,
	input  logic [bmp_pkg::INDEX_W-1:0]  wr_index,
	input  logic [bmp_pkg::LEN_W-1:0]    wr_data
);
	import bmp_pkg::*;

	job_t front_job;
	job_t queue_job;
	logic job_push;
	logic jobq_full;
	logic jobq_empty;
	logic jobq_pop;

	// Accumulating front end
	bmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.jobq_full (jobq_full),
		.job_push  (job_push),
		.job       (front_job)
	);

	// Job queue
	bmp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_push),
		.wr_job  (front_job),
		.q_full  (jobq_full),
		.rd      (jobq_pop),
		.rd_job  (queue_job),
		.q_empty (jobq_empty)
	);

	// Divider back end
	bmp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.jobq_empty (jobq_empty),
		.jobq_data  (queue_job),
		.jobq_pop   (jobq_pop),
		.empty      (empty),
		.pop        (pop),
		.mean_power (mean_power),
		.channel    (channel),
		.last       (last)
	);

endmodule

>>> sv/bmp_checker.sv
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks on the result channel of block_mean_power_top.
// ----------------------------------------------------------------------------
module bmp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         pop,
	input logic [bmp_pkg::MEAN_W-1:0]   mean_power,
	input logic                         channel,
	input logic                         last
);
	import bmp_pkg::*;

	// Channel 1 only ever closes a two-channel pair
	a_chan1_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && channel) |-> last)
		else $error("channel 1 result without last");

	// A mean never exceeds 2^32: top bit set means the rest is zero
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mean_power[MEAN_W-1]) |-> (mean_power[MEAN_W-2:0] == '0))
		else $error("mean_power out of range");

	// Once channel 0 of a pair is taken, the next beat shown is channel 1
	a_chan0_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> (empty || channel))
		else $error("channel 0 result not followed by its pair");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(mean_power) && $stable(channel)
			&& $stable(last)))
		else $error("result changed while waiting");

endmodule

bind block_mean_power_top bmp_checker u_bmp_checker (.*);

>>> tb/block_mean_power_top_tb.sv
// ----------------------------------------------------------------------------
// block_mean_power_top_tb
// Self-checking bench for the block mean-square power integrator. A tracker
// object keeps its own copy of the registers and accumulators. It predicts
// the mean_power / channel / last beats for every accepted sample and checks
// each popped beat against the oldest prediction. Plain tasks drive a short
// directed pass over the corner cases, then random phases. The random phases
// use random register settings and four idle profiles, plus one stretch of
// receiver back-pressure that fills the job queue and stalls the sample input.
// ----------------------------------------------------------------------------
module block_mean_power_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmp_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_GAP = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_GAP = 60;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 950;

	// Codes the package leaves unnamed
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [INDEX_W-1:0] REG_SPARE_B = 2'd3;

	// Sample corner values
	localparam logic [SAMPLE_W-1:0] S_MIN = 8'h80;
	localparam logic [SAMPLE_W-1:0] S_MAX = 8'h7F;
	localparam logic [SAMPLE_W-1:0] S_NEG1 = 8'hFF;
	localparam logic [SAMPLE_W-1:0] S_ZERO = 8'h00;
	localparam logic [SAMPLE_W-1:0] S_ONE = 8'h01;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic              chan;
		logic              fin;
	} mean_beat_t;

	// Tracks registers and accumulators; holds the mean beats still owed
	class mean_power_tracker;
		logic [MODE_W-1:0] mode_q;
		logic [LEN_W-1:0]  len_q;
		longint unsigned   sum_a;
		longint unsigned   sum_b;
		int                held;
		int                terms;
		bit                odd;
		mean_beat_t        awaited[$];
		int                errors;
		int                samples;
		int                results;
		int                writes;

		function new();
			mode_q = MODE_SINGLE;
			len_q = LEN_W'(LEN_RESET);
			restart();
			errors = 0;
			samples = 0;
			results = 0;
			writes = 0;
		endfunction

		function void restart();
			sum_a = 0;
			sum_b = 0;
			held = 0;
			terms = 0;
			odd = 1'b0;
		endfunction

		// Truncated fixed-point quotient
		function logic [MEAN_W-1:0] block_mean(longint unsigned sum, longint unsigned len);
			longint unsigned q;
			q = (sum << FRAC_BITS) / len;
			return q[MEAN_W-1:0];
		endfunction

		function void apply_write(logic [INDEX_W-1:0] idx, logic [LEN_W-1:0] data);
			writes++;
			if (idx == REG_MODE) begin
				mode_q = data[MODE_W-1:0];
				restart();
			end else if (idx == REG_BLOCK_LENGTH) begin
				len_q = data;
				restart();
			end
		endfunction

		function void take_sample(logic [SAMPLE_W-1:0] smp);
			int s;
			longint unsigned len;
			mean_beat_t b;
			s = $signed(smp);
			samples++;
			len = (len_q == 0) ? 1 : len_q;
			if (len > MAX_BLOCK)
				len = MAX_BLOCK;
			// pair modes hold the even sample until its partner arrives
			if (mode_q == MODE_DUAL || mode_q == MODE_PAIR) begin
				if (!odd) begin
					held = s;
					odd = 1'b1;
					return;
				end
				odd = 1'b0;
				if (mode_q == MODE_DUAL) begin
					sum_a += longint'(held * held);
					sum_b += longint'(s * s);
				end else begin
					sum_a += longint'((held + s) * (held + s));
				end
				held = 0;
			end else begin
				sum_a += longint'(s * s);
			end
			terms++;
			if (terms < len)
				return;
			b.mean = block_mean(sum_a, len);
			b.chan = 1'b0;
			b.fin = (mode_q != MODE_DUAL);
			awaited.push_back(b);
			if (mode_q == MODE_DUAL) begin
				b.mean = block_mean(sum_b, len);
				b.chan = 1'b1;
				b.fin = 1'b1;
				awaited.push_back(b);
			end
			sum_a = 0;
			sum_b = 0;
			terms = 0;
		endfunction

		function void match_result(logic [MEAN_W-1:0] mean, logic chan, logic fin);
			mean_beat_t want;
			results++;
			if (awaited.size() == 0) begin
				$error("unexpected beat: mean_power %0d channel %0d last %0d", mean, chan, fin);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (mean !== want.mean) begin
				$error("mean_power: expected %0d, actual %0d", want.mean, mean);
				errors++;
			end
			if (chan !== want.chan) begin
				$error("channel: expected %0d, actual %0d", want.chan, chan);
				errors++;
			end
			if (fin !== want.fin) begin
				$error("last: expected %0d, actual %0d", want.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [MEAN_W-1:0]   mean_power;
	logic                channel;
	logic                last;
	logic                wr_en = 1'b0;
	logic [INDEX_W-1:0]  wr_index = '0;
	logic [LEN_W-1:0]    wr_data = '0;

	mean_power_tracker tracker = new();
	int tx_pct = 0;
	int rx_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;
	int phase;

	block_mean_power_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.mean_power(mean_power),
		.channel(channel),
		.last(last),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Monitor: register writes, accepted beats, stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				tracker.apply_write(wr_index, wr_data);
			if (push && !full)
				tracker.take_sample(sample);
			if (pop && !empty)
				tracker.match_result(mean_power, channel, last);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				pop <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			pop <= ($urandom_range(99) >= rx_pct);
		end
	end

	task automatic cfg_write(logic [INDEX_W-1:0] idx, logic [LEN_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// push stays high between back-to-back beats; lowered only for gaps
	task automatic send_sample(logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample <= smp;
		do @(posedge clk); while (full);
	endtask

	// Stop sending and wait until every predicted beat has been popped; the
	// monitor logs the last accepted sample before the wait starts
	task automatic end_burst();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic set_profile(int p);
		case (p)
			0: begin tx_pct = 0; rx_pct = 0; end
			1: begin tx_pct = 87; rx_pct = 0; end
			2: begin tx_pct = 0; rx_pct = 87; end
			default: begin tx_pct = 24; rx_pct = 24; end
		endcase
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(4))
				0: return S_MIN;
				1: return S_MAX;
				2: return S_ZERO;
				3: return S_NEG1;
				default: return S_ONE;
			endcase
		end
		return SAMPLE_W'($urandom());
	endfunction

	task automatic random_phase(int count, int profile);
		logic [LEN_W-1:0] len_val;
		int pick;
		set_profile(profile);
		pick = $urandom_range(99);
		if (pick < 45)
			len_val = LEN_W'($urandom_range(1, 4));
		else if (pick < 75)
			len_val = LEN_W'($urandom_range(5, 16));
		else if (pick < 92)
			len_val = LEN_W'($urandom_range(17, 64));
		else if (pick < 96)
			len_val = '0;
		else
			len_val = LEN_W'(1);
		// mode data carries random upper bits; all four codes come up
		if ($urandom_range(1)) begin
			cfg_write(REG_MODE, LEN_W'($urandom()));
			cfg_write(REG_BLOCK_LENGTH, len_val);
		end else begin
			cfg_write(REG_BLOCK_LENGTH, len_val);
			cfg_write(REG_MODE, LEN_W'($urandom()));
		end
		if ($urandom_range(3) == 0)
			cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, LEN_W'($urandom()));
		repeat (count) send_sample(random_sample());
		end_burst();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_profile(0);

		// single channel, one-sample blocks over the sample extremes
		cfg_write(REG_BLOCK_LENGTH, LEN_W'(1));
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(S_ZERO);
		send_sample(S_NEG1);
		send_sample(S_ONE);
		end_burst();

		// two channels; the trailing even sample is dropped by the next write
		cfg_write(REG_MODE, LEN_W'(MODE_DUAL));
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(S_ZERO);
		send_sample(S_MIN);
		send_sample(S_MAX);
		end_burst();

		// pair sum; both at the minimum gives the largest mean
		cfg_write(REG_MODE, LEN_W'(MODE_PAIR));
		send_sample(S_MIN);
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(S_MAX);
		end_burst();

		// spare mode code acts as single channel; quotient truncates
		cfg_write(REG_MODE, LEN_W'(MODE_SPARE));
		cfg_write(REG_BLOCK_LENGTH, LEN_W'(3));
		send_sample(S_ONE);
		send_sample(S_ZERO);
		send_sample(S_ZERO);
		end_burst();

		// zero length counts as one
		cfg_write(REG_BLOCK_LENGTH, '0);
		send_sample(8'd7);
		end_burst();

		// oversize length saturates; the partial block is discarded later
		cfg_write(REG_BLOCK_LENGTH, {LEN_W{1'b1}});
		send_sample(S_MAX);
		send_sample(S_MIN);
		end_burst();

		// writes to unused indexes must not restart a block in progress
		cfg_write(REG_MODE, LEN_W'(MODE_SINGLE));
		cfg_write(REG_BLOCK_LENGTH, LEN_W'(4));
		send_sample(8'd3);
		send_sample(S_NEG1);
		end_burst();
		cfg_write(REG_SPARE_A, {LEN_W{1'b1}});
		cfg_write(REG_SPARE_B, '0);
		send_sample(8'd5);
		send_sample(S_MIN);
		end_burst();

		// random phases cycle through the idle profiles
		phase = 0;
		while (tracker.samples < ITEM_TARGET) begin
			random_phase($urandom_range(30, 70), phase % 4);
			phase++;
			if (phase == 6) begin
				// long receiver hold-off under a dense dual stream fills the job queue
				set_profile(0);
				cfg_write(REG_MODE, LEN_W'(MODE_DUAL));
				cfg_write(REG_BLOCK_LENGTH, LEN_W'(1));
				hold_off = HOLD_CYCLES;
				repeat (80) send_sample(random_sample());
				end_burst();
			end
		end
		end_burst();

		if (tracker.awaited.size() != 0) begin
			$error("%0d predicted beats never arrived", tracker.awaited.size());
			tracker.errors++;
		end
		$display("Run covered %0d samples, %0d result beats, %0d register writes in %0d phases",
			tracker.samples, tracker.results, tracker.writes, phase);
		$display("over all mode codes, lengths from zero past the cap, idle and hold-off stretches");
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
sv/bmp_pkg.sv
sv/bmp_front.sv
sv/bmp_queue.sv
sv/bmp_back.sv
sv/block_mean_power_top.sv
sv/bmp_checker.sv
tb/block_mean_power_top_tb.sv
